>>> design/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");

// Implication whose consequent is checked on the clock edge after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed");

`endif

>>> design/edf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package edf_pkg;
    localparam int unsigned CAPACITY_DEF = 1024;
    localparam int unsigned BUCKETS_DEF = 256;
    localparam logic [31:0] EXPIRE_RESET = 32'd86400;

    localparam logic [1:0] OP_CHECK = 2'd0;
    localparam logic [1:0] OP_ADD = 2'd1;
    localparam logic [1:0] OP_EXPIRE = 2'd2;

    localparam logic [2:0] ST_DUP = 3'd0;
    localparam logic [2:0] ST_MISS = 3'd1;
    localparam logic [2:0] ST_ADDED = 3'd2;
    localparam logic [2:0] ST_FULL = 3'd3;
    localparam logic [2:0] ST_EXPIRED = 3'd4;

    typedef struct packed {
        logic [1:0] operation;
        logic [31:0] key_a;
        logic [31:0] key_b;
        logic [31:0] key_c;
        logic [31:0] now;
    } req_t;

    typedef struct packed {
        logic [2:0] status;
        logic [10:0] removed_count;
    } rsp_t;
endpackage
`default_nettype wire

>>> design/edf_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface edf_req_if;
    logic valid;
    logic ready;
    edf_pkg::req_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> design/edf_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface edf_rsp_if;
    logic valid;
    logic ready;
    edf_pkg::rsp_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> design/expiring_duplicate_filter_core.sv
// Channel   | Direction | Payload
// in_ch     | sink      | operation, key_a, key_b, key_c, now
// out_ch    | source    | status, removed_count
// Check walks the bucket's chain entry by entry; add writes the new entry and,
// when the bucket already holds an entry, links the old head back to it; an add
// to a full table is answered with the full status. Expire frees aged entries
// one at a time; each step is bound by the one read port of the entry memory and
// the bucket head memory. After reset a clearing pass nulls the bucket heads; no
// transaction is taken meanwhile. One transaction is in work at a time, and a
// result waiting in the output register holds off the next input.
`timescale 1ns / 1ps
`default_nettype none
module expiring_duplicate_filter_core #(
    parameter int unsigned CAPACITY = edf_pkg::CAPACITY_DEF,
    parameter int unsigned BUCKETS = edf_pkg::BUCKETS_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    edf_req_if.sink in_ch,
    edf_rsp_if.source out_ch,
    input wire logic cfg_we,
    input wire logic [31:0] cfg_wdata
);
    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned LW = $clog2(CAPACITY + 1);
    localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int unsigned BCW = $clog2(BUCKETS + 1);
    localparam int unsigned DW = 96 + 32 + 2 * LW;
    localparam logic [LW-1:0] NULL_LINK = LW'(CAPACITY);

    typedef struct packed {
        logic [LW-1:0] prev;
        logic [LW-1:0] next;
        logic [31:0] stamp;
        logic [31:0] kc;
        logic [31:0] kb;
        logic [31:0] ka;
    } entry_t;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_HRD, S_HWAIT, S_WALK, S_WWAIT, S_CMP,
        S_AWR, S_AOLD_RD, S_AOLD_WAIT, S_AOLD_WR,
        S_ERD, S_EWAIT, S_ECHK, S_EPRD, S_EPWAIT, S_EPWR,
        S_ENRD, S_ENWAIT, S_ENWR, S_EHEAD, S_DONE
    } state_t;

    state_t state_reg;
    edf_pkg::req_t req_reg;
    logic [31:0] expire_reg;
    logic [AW-1:0] age_head_reg;
    logic [LW-1:0] live_reg;
    logic [LW-1:0] cur_reg;
    logic [LW-1:0] guard_reg;
    logic [10:0] removed_reg;
    logic [BCW-1:0] clr_reg;
    entry_t ent_reg;
    logic out_valid_reg;
    edf_pkg::rsp_t out_reg;

    logic mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    entry_t mem_wdata;
    logic [DW-1:0] mem_rdata;
    entry_t rd;

    logic [LW-1:0] bh_mem [0:BUCKETS-1];
    logic bh_we;
    logic [BW-1:0] bh_waddr;
    logic [BW-1:0] bh_raddr;
    logic [LW-1:0] bh_wdata;
    logic [LW-1:0] bh_rdata;

    logic [BW-1:0] bucket;
    logic [BW-1:0] ent_bucket;
    logic [AW-1:0] slot;
    logic [LW:0] slot_sum;
    logic key_eq;
    logic aged;

    edf_entry_mem #(.AW(AW), .DW(DW)) u_mem (
        .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
        .raddr(mem_raddr), .rdata(mem_rdata)
    );

    assign rd = entry_t'(mem_rdata);
    assign bucket = BW'(req_reg.key_a % BUCKETS);
    assign ent_bucket = BW'(ent_reg.ka % BUCKETS);
    assign slot_sum = (LW + 1)'(age_head_reg) + (LW + 1)'(live_reg);
    assign slot = (slot_sum >= (LW + 1)'(CAPACITY)) ?
        AW'(slot_sum - (LW + 1)'(CAPACITY)) : AW'(slot_sum);
    assign key_eq = (rd.ka == req_reg.key_a) && (rd.kb == req_reg.key_b)
        && (rd.kc == req_reg.key_c);
    assign aged = (req_reg.now >= rd.stamp) && ((req_reg.now - rd.stamp) >= expire_reg);

    assign in_ch.ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.payload = out_reg;

    always_ff @(posedge clk)
    begin
        if (bh_we)
        begin
            bh_mem[bh_waddr] <= bh_wdata;
        end
        bh_rdata <= bh_mem[bh_raddr];
    end

    always_comb
    begin
        mem_we = 1'b0;
        mem_waddr = cur_reg[AW-1:0];
        mem_wdata = ent_reg;
        mem_raddr = cur_reg[AW-1:0];
        bh_we = 1'b0;
        bh_waddr = bucket;
        bh_raddr = bucket;
        bh_wdata = NULL_LINK;
        case (state_reg)
            S_CLEAR:
            begin
                bh_we = 1'b1;
                bh_waddr = BW'(clr_reg);
            end
            S_AWR:
            begin
                mem_we = 1'b1;
                mem_waddr = slot;
                mem_wdata.ka = req_reg.key_a;
                mem_wdata.kb = req_reg.key_b;
                mem_wdata.kc = req_reg.key_c;
                mem_wdata.stamp = req_reg.now;
                mem_wdata.prev = NULL_LINK;
                mem_wdata.next = bh_rdata;
                bh_we = 1'b1;
                bh_wdata = LW'(slot);
            end
            S_AOLD_WR:
            begin
                mem_we = 1'b1;
                mem_wdata.prev = LW'(slot);
            end
            S_ERD, S_EWAIT:
            begin
                mem_raddr = age_head_reg;
            end
            S_EPRD, S_EPWAIT:
            begin
                mem_raddr = ent_reg.prev[AW-1:0];
            end
            S_EPWR:
            begin
                mem_we = 1'b1;
                mem_waddr = ent_reg.prev[AW-1:0];
                mem_wdata = rd;
                mem_wdata.next = ent_reg.next;
            end
            S_EHEAD:
            begin
                bh_we = 1'b1;
                bh_waddr = ent_bucket;
                bh_wdata = ent_reg.next;
            end
            S_ENRD, S_ENWAIT:
            begin
                mem_raddr = ent_reg.next[AW-1:0];
            end
            S_ENWR:
            begin
                mem_we = (ent_reg.next < NULL_LINK);
                mem_waddr = ent_reg.next[AW-1:0];
                mem_wdata = rd;
                mem_wdata.prev = ent_reg.prev;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            expire_reg <= edf_pkg::EXPIRE_RESET;
            age_head_reg <= '0;
            live_reg <= '0;
            clr_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                expire_reg <= cfg_wdata;
            end
            if (out_valid_reg && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == BCW'(BUCKETS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_ch.valid && in_ch.ready)
                    begin
                        req_reg <= in_ch.payload;
                        removed_reg <= '0;
                        guard_reg <= '0;
                        case (in_ch.payload.operation)
                            edf_pkg::OP_CHECK: state_reg <= S_HRD;
                            edf_pkg::OP_ADD: state_reg <= S_HRD;
                            edf_pkg::OP_EXPIRE: state_reg <= S_ERD;
                            default:
                            begin
                                out_reg.status <= edf_pkg::ST_MISS;
                                out_reg.removed_count <= '0;
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_HRD:
                begin
                    if (req_reg.operation == edf_pkg::OP_ADD
                        && live_reg == NULL_LINK)
                    begin
                        out_reg.status <= edf_pkg::ST_FULL;
                        out_reg.removed_count <= '0;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_HWAIT;
                    end
                end
                S_HWAIT:
                begin
                    cur_reg <= bh_rdata;
                    if (req_reg.operation == edf_pkg::OP_ADD)
                    begin
                        state_reg <= S_AWR;
                    end
                    else
                    begin
                        state_reg <= S_WALK;
                    end
                end
                S_WALK:
                begin
                    if (cur_reg >= NULL_LINK || guard_reg == NULL_LINK)
                    begin
                        out_reg.status <= edf_pkg::ST_MISS;
                        out_reg.removed_count <= '0;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_WWAIT;
                    end
                end
                S_WWAIT:
                begin
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (key_eq)
                    begin
                        out_reg.status <= edf_pkg::ST_DUP;
                        out_reg.removed_count <= '0;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        cur_reg <= rd.next;
                        guard_reg <= guard_reg + 1'b1;
                        state_reg <= S_WALK;
                    end
                end
                S_AWR:
                begin
                    if (cur_reg < NULL_LINK)
                    begin
                        state_reg <= S_AOLD_RD;
                    end
                    else
                    begin
                        live_reg <= live_reg + 1'b1;
                        out_reg.status <= edf_pkg::ST_ADDED;
                        out_reg.removed_count <= '0;
                        state_reg <= S_DONE;
                    end
                end
                S_AOLD_RD: state_reg <= S_AOLD_WAIT;
                S_AOLD_WAIT:
                begin
                    ent_reg <= rd;
                    state_reg <= S_AOLD_WR;
                end
                S_AOLD_WR:
                begin
                    live_reg <= live_reg + 1'b1;
                    out_reg.status <= edf_pkg::ST_ADDED;
                    out_reg.removed_count <= '0;
                    state_reg <= S_DONE;
                end
                S_ERD:
                begin
                    if (live_reg == '0)
                    begin
                        out_reg.status <= edf_pkg::ST_EXPIRED;
                        out_reg.removed_count <= removed_reg;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_EWAIT;
                    end
                end
                S_EWAIT: state_reg <= S_ECHK;
                S_ECHK:
                begin
                    ent_reg <= rd;
                    if (!aged)
                    begin
                        out_reg.status <= edf_pkg::ST_EXPIRED;
                        out_reg.removed_count <= removed_reg;
                        state_reg <= S_DONE;
                    end
                    else if (rd.prev < NULL_LINK)
                    begin
                        state_reg <= S_EPRD;
                    end
                    else
                    begin
                        state_reg <= S_EHEAD;
                    end
                end
                S_EPRD: state_reg <= S_EPWAIT;
                S_EPWAIT: state_reg <= S_EPWR;
                S_EPWR: state_reg <= S_ENRD;
                S_EHEAD: state_reg <= S_ENRD;
                S_ENRD:
                begin
                    if (ent_reg.next < NULL_LINK)
                    begin
                        state_reg <= S_ENWAIT;
                    end
                    else
                    begin
                        state_reg <= S_ENWR;
                    end
                end
                S_ENWAIT: state_reg <= S_ENWR;
                S_ENWR:
                begin
                    age_head_reg <= (age_head_reg == AW'(CAPACITY - 1)) ?
                        '0 : age_head_reg + 1'b1;
                    live_reg <= live_reg - 1'b1;
                    removed_reg <= removed_reg + 1'b1;
                    state_reg <= S_ERD;
                end
                S_DONE:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> design/edf_entry_mem.sv
`timescale 1ns / 1ps
`default_nettype none
module edf_entry_mem #(
    parameter int unsigned AW = 10,
    parameter int unsigned DW = 139
) (
    input wire logic clk,
    input wire logic we,
    input wire logic [AW-1:0] waddr,
    input wire logic [DW-1:0] wdata,
    input wire logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);
    logic [DW-1:0] mem [0:(1 << AW)-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> design/edf_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module edf_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic [2:0] status,
    input wire logic [10:0] removed_count
);
    `ASSERT_IMPLY(a_status_range, clk, rst_n, out_valid, status <= edf_pkg::ST_EXPIRED)
    `ASSERT_IMPLY(a_count_only_expire, clk, rst_n,
        out_valid && status != edf_pkg::ST_EXPIRED, removed_count == 11'd0)
    `ASSERT_NEXT(a_out_holds, clk, rst_n, out_valid && !out_ready, out_valid)
    `ASSERT_NEXT(a_no_instant, clk, rst_n, in_valid && in_ready, !in_ready)
endmodule

bind expiring_duplicate_filter_core edf_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .status(out_ch.payload.status),
    .removed_count(out_ch.payload.removed_count)
);
`default_nettype wire
